/* hdl/polar_active_stress_tensor_defines.svh */
// Assertion macros for the checker file.
`ifndef POLAR_ACTIVE_STRESS_TENSOR_DEFINES_SVH
`define POLAR_ACTIVE_STRESS_TENSOR_DEFINES_SVH

// Clocked property, off while reset is low.
`define PATE_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pate assertion failed");

// Clocked property, checked during reset too.
`define PATE_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("pate assertion failed");

`endif

/* hdl/pate_pkg.sv */
`default_nettype none
package pate_pkg;

  localparam int FRAC         = 12;
  localparam int WIDE_W       = 42;
  localparam int MID_W        = WIDE_W + 1;
  localparam int ACC_W        = 52;
  localparam int PROD_W       = 59;
  localparam int EXT_W        = 72;
  localparam int OUT_W        = 32;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int STAGES       = 15;
  localparam int FRONT_STAGES = 6;
  localparam int THIRD_STAGES = 3;
  localparam int THIRD_SPLIT  = 22;
  localparam int THIRD_SHIFT  = 25;
  localparam logic [20:0] THIRD_K = 21'd1398101;
  localparam logic [23:0] THIRD_M = 24'd11184811;

  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [MID_W-1:0]  mid_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [EXT_W-1:0]  ext_t;
  typedef logic signed [OUT_W-1:0]  out_t;
  typedef logic signed [CFG_W-1:0]  cfg_word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_A,
    CFG_COEF_B,
    CFG_ELASTIC_ONE,
    CFG_ELASTIC_TWO,
    CFG_ACTIVITY,
    CFG_FLOW_ALIGN
  } cfg_idx_e;

  typedef struct packed {
    cfg_word_t coef_a;
    cfg_word_t coef_b;
    cfg_word_t elastic_one;
    cfg_word_t elastic_two;
    cfg_word_t activity;
    cfg_word_t flow_align;
  } cfg_t;

  localparam ext_t WIDE_HI = (ext_t'(1) <<< (WIDE_W - 1)) - ext_t'(1);
  localparam ext_t WIDE_LO = -WIDE_HI - ext_t'(1);
  localparam ext_t OUT_HI  = (ext_t'(1) <<< (OUT_W - 1)) - ext_t'(1);
  localparam ext_t OUT_LO  = -OUT_HI - ext_t'(1);

  // round half up, then floor
  function automatic ext_t rnd_sh(input ext_t x, input int unsigned sh);
    rnd_sh = (x + (ext_t'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic wide_t sat_w(input ext_t x);
    if (x > WIDE_HI) begin
      sat_w = wide_t'(WIDE_HI[WIDE_W-1:0]);
    end else if (x < WIDE_LO) begin
      sat_w = wide_t'(WIDE_LO[WIDE_W-1:0]);
    end else begin
      sat_w = wide_t'(x[WIDE_W-1:0]);
    end
  endfunction

  function automatic out_t sat_o(input ext_t x);
    if (x > OUT_HI) begin
      sat_o = out_t'(OUT_HI[OUT_W-1:0]);
    end else if (x < OUT_LO) begin
      sat_o = out_t'(OUT_LO[OUT_W-1:0]);
    end else begin
      sat_o = out_t'(x[OUT_W-1:0]);
    end
  endfunction

  function automatic acc_t to_acc(input ext_t x);
    to_acc = acc_t'(x[ACC_W-1:0]);
  endfunction

endpackage
`default_nettype wire

/* hdl/pate_third.sv */
`default_nettype none
module pate_third (
  input  wire logic                                clk_i,
  input  wire logic [pate_pkg::THIRD_STAGES-1:0]   en_i,
  input  wire pate_pkg::wide_t                     x_i,
  output pate_pkg::wide_t                          y_o
);

  localparam int WW    = pate_pkg::WIDE_W;
  localparam int SPLIT = pate_pkg::THIRD_SPLIT;
  localparam int HIW   = WW - SPLIT;
  localparam int SUMW  = SPLIT + 1;
  localparam int KW    = $bits(pate_pkg::THIRD_K);
  localparam int MW    = $bits(pate_pkg::THIRD_M);
  localparam int HQW   = HIW + KW;
  localparam int LPW   = SUMW + MW;
  localparam int LQW   = LPW - pate_pkg::THIRD_SHIFT;
  localparam logic [WW-1:0] ONE_W = 1;

  logic [WW:0]     ext_w;
  logic [WW:0]     neg_w;
  logic [WW-1:0]   mag_d, mag_q;
  logic            neg1_q, neg2_q;
  logic [HIW-1:0]  hi_w;
  logic [SPLIT-1:0] lo_w;
  logic [SUMW-1:0] sum_w;
  logic [LPW-1:0]  lprod_w;
  logic [HQW-1:0]  hq_d, hq_q;
  logic [LQW-1:0]  lq_d, lq_q;
  logic [WW-1:0]   tot_w;
  pate_pkg::wide_t y_d, y_q;

  always_comb begin
    ext_w   = {x_i[WW-1], x_i};
    neg_w   = -ext_w;
    mag_d   = (x_i[WW-1] ? neg_w[WW-1:0] : ext_w[WW-1:0]) + ONE_W;
    hi_w    = mag_q[WW-1:SPLIT];
    lo_w    = mag_q[SPLIT-1:0];
    sum_w   = SUMW'(hi_w) + SUMW'(lo_w);
    hq_d    = HQW'(hi_w) * HQW'(pate_pkg::THIRD_K);
    lprod_w = LPW'(sum_w) * LPW'(pate_pkg::THIRD_M);
    lq_d    = lprod_w[LPW-1:pate_pkg::THIRD_SHIFT];
    tot_w   = WW'(hq_q) + WW'(lq_q);
    y_d     = neg2_q ? -pate_pkg::wide_t'(tot_w) : pate_pkg::wide_t'(tot_w);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mag_q  <= mag_d;
      neg1_q <= x_i[WW-1];
    end
    if (en_i[1]) begin
      hq_q   <= hq_d;
      lq_q   <= lq_d;
      neg2_q <= neg1_q;
    end
    if (en_i[2]) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule
`default_nettype wire

/* hdl/pate_front.sv */
`default_nettype none
module pate_front #(
  parameter int COMPONENT_WIDTH = 16
) (
  input  wire logic                                clk_i,
  input  wire logic [pate_pkg::FRONT_STAGES:1]     en_i,
  input  wire pate_pkg::cfg_t                      cfg_i,
  input  wire logic [3*COMPONENT_WIDTH-1:0]        polarization_i,
  input  wire logic [3*COMPONENT_WIDTH-1:0]        grad_row_x_i,
  input  wire logic [3*COMPONENT_WIDTH-1:0]        grad_row_y_i,
  input  wire logic [3*COMPONENT_WIDTH-1:0]        grad_row_z_i,
  input  wire logic [3*COMPONENT_WIDTH-1:0]        laplacian_vec_i,
  input  wire logic [3*COMPONENT_WIDTH-1:0]        dyad_lap_row_x_i,
  input  wire logic [3*COMPONENT_WIDTH-1:0]        dyad_lap_row_y_i,
  input  wire logic [3*COMPONENT_WIDTH-1:0]        dyad_lap_row_z_i,
  output logic signed [COMPONENT_WIDTH-1:0]        p_o   [3],
  output pate_pkg::wide_t                          h_o   [3],
  output pate_pkg::mid_t                           ppd_o [3][3],
  output pate_pkg::acc_t                           kgr_o [3][3]
);

  localparam int CW   = COMPONENT_WIDTH;
  localparam int PW   = 2 * CW;
  localparam int CPW  = pate_pkg::CFG_W + CW;
  localparam int MUW  = pate_pkg::WIDE_W + CW;
  localparam int FR   = pate_pkg::FRAC;

  pate_pkg::cfg_word_t ca, cb, k1, k2;
  logic signed [CW-1:0] p [3];
  logic signed [CW-1:0] lp [3];
  logic signed [CW-1:0] g [3][3];
  logic signed [CW-1:0] dl [3][3];

  logic signed [CW-1:0]  p_q   [1:6][3];
  logic signed [PW-1:0]  pq_q  [1:5][3][3];
  pate_pkg::acc_t        hl_q  [2:5][3];
  pate_pkg::acc_t        s2_q  [4:5][3];
  pate_pkg::acc_t        kgr_q [4:6][3][3];

  logic signed [PW-1:0]  sq_d [3], sq_q [3];
  logic signed [PW-1:0]  sd_d [3][3], sd_q [3][3];
  logic signed [PW-1:0]  gp_d [3][3][3], gp_q [3][3][3];
  logic signed [PW-1:0]  pq_d [3][3];
  logic signed [CPW-1:0] ap_d [3], ap_q [3];
  logic signed [CPW-1:0] kl_d [3], kl_q [3];
  pate_pkg::wide_t       p2_d, p2_q;
  pate_pkg::wide_t       s_d [3], s_q [3];
  pate_pkg::wide_t       gg_d [3][3], gg_q [3][3];
  pate_pkg::acc_t        hl_d [3];
  logic signed [MUW-1:0] mu_d [3], mu_q [3];
  pate_pkg::prod_t       ms_d [3], ms_q [3];
  pate_pkg::prod_t       kg_d [3][3], kg_q [3][3];
  pate_pkg::wide_t       u_d [3], u_q [3];
  pate_pkg::acc_t        s2_d [3];
  pate_pkg::acc_t        kgr_d [3][3];
  pate_pkg::prod_t       mb_d [3], mb_q [3];
  pate_pkg::wide_t       h_d [3], h_q [3];
  pate_pkg::mid_t        ppd_d [3][3], ppd_q [3][3];
  pate_pkg::wide_t       t3_w;

  assign ca = cfg_i.coef_a;
  assign cb = cfg_i.coef_b;
  assign k1 = cfg_i.elastic_one;
  assign k2 = cfg_i.elastic_two;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      p[c]     = polarization_i[c*CW +: CW];
      lp[c]    = laplacian_vec_i[c*CW +: CW];
      g[0][c]  = grad_row_x_i[c*CW +: CW];
      g[1][c]  = grad_row_y_i[c*CW +: CW];
      g[2][c]  = grad_row_z_i[c*CW +: CW];
      dl[0][c] = dyad_lap_row_x_i[c*CW +: CW];
      dl[1][c] = dyad_lap_row_y_i[c*CW +: CW];
      dl[2][c] = dyad_lap_row_z_i[c*CW +: CW];
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sq_d[a] = p[a] * p[a];
      ap_d[a] = ca * p[a];
      kl_d[a] = k1 * lp[a];
      for (int b = 0; b < 3; b++) begin
        sd_d[a][b] = p[b] * dl[b][a];
        pq_d[a][b] = p[a] * p[b];
        for (int c = 0; c < 3; c++) begin
          gp_d[a][b][c] = g[a][c] * g[b][c];
        end
      end
    end
  end

  always_comb begin
    p2_d = pate_pkg::sat_w(pate_pkg::ext_t'(sq_q[0]) + pate_pkg::ext_t'(sq_q[1])
                           + pate_pkg::ext_t'(sq_q[2]));
    for (int a = 0; a < 3; a++) begin
      s_d[a]  = pate_pkg::sat_w(pate_pkg::ext_t'(sd_q[a][0]) + pate_pkg::ext_t'(sd_q[a][1])
                                + pate_pkg::ext_t'(sd_q[a][2]));
      hl_d[a] = pate_pkg::acc_t'(kl_q[a]) - pate_pkg::acc_t'(ap_q[a]);
      for (int b = 0; b < 3; b++) begin
        gg_d[a][b] = pate_pkg::sat_w(pate_pkg::ext_t'(gp_q[a][b][0])
                                     + pate_pkg::ext_t'(gp_q[a][b][1])
                                     + pate_pkg::ext_t'(gp_q[a][b][2]));
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mu_d[a] = p2_q * p_q[2][a];
      ms_d[a] = k2 * s_q[a];
      u_d[a]  = pate_pkg::sat_w(pate_pkg::rnd_sh(pate_pkg::ext_t'(mu_q[a]), FR));
      s2_d[a] = pate_pkg::to_acc(pate_pkg::rnd_sh(pate_pkg::ext_t'(ms_q[a]), FR - 1));
      mb_d[a] = cb * u_q[a];
      h_d[a]  = pate_pkg::sat_w(pate_pkg::ext_t'(hl_q[5][a])
                                - pate_pkg::rnd_sh(pate_pkg::ext_t'(mb_q[a]), FR)
                                + pate_pkg::ext_t'(s2_q[5][a]));
      for (int b = 0; b < 3; b++) begin
        kg_d[a][b]  = k1 * gg_q[a][b];
        kgr_d[a][b] = pate_pkg::to_acc(pate_pkg::rnd_sh(pate_pkg::ext_t'(kg_q[a][b]), FR));
        ppd_d[a][b] = pate_pkg::mid_t'(pq_q[5][a][b])
                      - ((a == b) ? pate_pkg::mid_t'(t3_w) : pate_pkg::mid_t'(0));
      end
    end
  end

  pate_third u_third_p2 (
    .clk_i (clk_i),
    .en_i  (en_i[5:3]),
    .x_i   (p2_q),
    .y_o   (t3_w)
  );

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p_q[1]  <= p;
      pq_q[1] <= pq_d;
      sq_q    <= sq_d;
      sd_q    <= sd_d;
      gp_q    <= gp_d;
      ap_q    <= ap_d;
      kl_q    <= kl_d;
    end
    if (en_i[2]) begin
      p_q[2]  <= p_q[1];
      pq_q[2] <= pq_q[1];
      p2_q    <= p2_d;
      s_q     <= s_d;
      gg_q    <= gg_d;
      hl_q[2] <= hl_d;
    end
    if (en_i[3]) begin
      p_q[3]  <= p_q[2];
      pq_q[3] <= pq_q[2];
      hl_q[3] <= hl_q[2];
      mu_q    <= mu_d;
      ms_q    <= ms_d;
      kg_q    <= kg_d;
    end
    if (en_i[4]) begin
      p_q[4]   <= p_q[3];
      pq_q[4]  <= pq_q[3];
      hl_q[4]  <= hl_q[3];
      u_q      <= u_d;
      s2_q[4]  <= s2_d;
      kgr_q[4] <= kgr_d;
    end
    if (en_i[5]) begin
      p_q[5]   <= p_q[4];
      pq_q[5]  <= pq_q[4];
      hl_q[5]  <= hl_q[4];
      s2_q[5]  <= s2_q[4];
      kgr_q[5] <= kgr_q[4];
      mb_q     <= mb_d;
    end
    if (en_i[6]) begin
      p_q[6]   <= p_q[5];
      kgr_q[6] <= kgr_q[5];
      h_q      <= h_d;
      ppd_q    <= ppd_d;
    end
  end

  assign p_o   = p_q[6];
  assign h_o   = h_q;
  assign ppd_o = ppd_q;
  assign kgr_o = kgr_q[6];

endmodule
`default_nettype wire

/* hdl/pate_back.sv */
`default_nettype none
module pate_back #(
  parameter int COMPONENT_WIDTH = 16
) (
  input  wire logic                                              clk_i,
  input  wire logic [pate_pkg::STAGES:pate_pkg::FRONT_STAGES+1]  en_i,
  input  wire pate_pkg::cfg_t                                    cfg_i,
  input  wire logic signed [COMPONENT_WIDTH-1:0]                 p_i   [3],
  input  wire pate_pkg::wide_t                                   h_i   [3],
  input  wire pate_pkg::mid_t                                    ppd_i [3][3],
  input  wire pate_pkg::acc_t                                    kgr_i [3][3],
  output pate_pkg::out_t                                         stress_o [9]
);

  localparam int CW  = COMPONENT_WIDTH;
  localparam int PHW = pate_pkg::WIDE_W + CW;
  localparam int FR  = pate_pkg::FRAC;

  pate_pkg::cfg_word_t zeta, lam;

  logic signed [PHW-1:0] ph_d [3][3], ph_q [3][3];
  pate_pkg::prod_t       zp_d [3][3], zp_q [3][3];
  pate_pkg::acc_t        kgr_q [3][3];
  pate_pkg::wide_t       pdoth_d, pdoth_q;
  pate_pkg::wide_t       anti_d [3][3];
  pate_pkg::wide_t       sym_d [3][3];
  pate_pkg::acc_t        q_d [3][3];
  pate_pkg::wide_t       anti_q [8:13][3][3];
  pate_pkg::wide_t       sym_q [8:11][3][3];
  pate_pkg::acc_t        q_q [8:13][3][3];
  pate_pkg::mid_t        symd_d [3][3], symd_q [3][3];
  pate_pkg::prod_t       ls_d [3][3], ls_q [3][3];
  pate_pkg::acc_t        tot_d [3][3], tot_q [3][3];
  pate_pkg::out_t        out_d [9], out_q [9];
  pate_pkg::wide_t       t3_w;

  assign zeta = cfg_i.activity;
  assign lam  = cfg_i.flow_align;

  always_comb begin
    pdoth_d = pate_pkg::sat_w(pate_pkg::rnd_sh(pate_pkg::ext_t'(ph_q[0][0])
                                               + pate_pkg::ext_t'(ph_q[1][1])
                                               + pate_pkg::ext_t'(ph_q[2][2]), FR));
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        ph_d[a][b]   = p_i[a] * h_i[b];
        zp_d[a][b]   = zeta * ppd_i[a][b];
        anti_d[a][b] = pate_pkg::sat_w(pate_pkg::rnd_sh(pate_pkg::ext_t'(ph_q[a][b])
                                       - pate_pkg::ext_t'(ph_q[b][a]), FR + 1));
        sym_d[a][b]  = pate_pkg::sat_w(pate_pkg::rnd_sh(pate_pkg::ext_t'(ph_q[a][b])
                                       + pate_pkg::ext_t'(ph_q[b][a]), FR + 1));
        q_d[a][b]    = pate_pkg::to_acc(pate_pkg::ext_t'(kgr_q[a][b])
                                        + pate_pkg::rnd_sh(pate_pkg::ext_t'(zp_q[a][b]), FR));
        symd_d[a][b] = pate_pkg::mid_t'(sym_q[11][a][b])
                       - ((a == b) ? pate_pkg::mid_t'(t3_w) : pate_pkg::mid_t'(0));
        ls_d[a][b]   = lam * symd_q[a][b];
        tot_d[a][b]  = pate_pkg::to_acc(pate_pkg::ext_t'(anti_q[13][a][b])
                                        - pate_pkg::rnd_sh(pate_pkg::ext_t'(ls_q[a][b]), FR)
                                        - pate_pkg::ext_t'(q_q[13][a][b]));
        out_d[a*3+b] = pate_pkg::sat_o(-pate_pkg::ext_t'(tot_q[a][b]));
      end
    end
  end

  pate_third u_third_pdoth (
    .clk_i (clk_i),
    .en_i  (en_i[11:9]),
    .x_i   (pdoth_q),
    .y_o   (t3_w)
  );

  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      ph_q  <= ph_d;
      zp_q  <= zp_d;
      kgr_q <= kgr_i;
    end
    if (en_i[8]) begin
      pdoth_q   <= pdoth_d;
      anti_q[8] <= anti_d;
      sym_q[8]  <= sym_d;
      q_q[8]    <= q_d;
    end
    for (int k = 9; k <= 11; k++) begin
      if (en_i[k]) begin
        sym_q[k] <= sym_q[k-1];
      end
    end
    for (int k = 9; k <= 13; k++) begin
      if (en_i[k]) begin
        anti_q[k] <= anti_q[k-1];
        q_q[k]    <= q_q[k-1];
      end
    end
    if (en_i[12]) begin
      symd_q <= symd_d;
    end
    if (en_i[13]) begin
      ls_q <= ls_d;
    end
    if (en_i[14]) begin
      tot_q <= tot_d;
    end
    if (en_i[15]) begin
      out_q <= out_d;
    end
  end

  assign stress_o = out_q;

endmodule
`default_nettype wire

/* hdl/polar_active_stress_tensor.sv */
// Channel  Handshake                  Payload
// in       in_valid_i / in_ready_o    polarization_i .. dyad_lap_row_z_i
// out      out_valid_o / out_ready_i  stress_xx_o .. stress_zz_o
// cfg      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One word per cycle while the output is not stalled.
// Fifteen register stages, set by the molecular field chain and two divide-by-three units.
// A stage loads when it is empty or the stage after it moves; bubbles collapse under stall.
// Reset clears the valid bits and the coefficient registers to zero.
// cfg_ready_o is always high.
`default_nettype none
module polar_active_stress_tensor #(
  parameter int COMPONENT_WIDTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic [3*COMPONENT_WIDTH-1:0]           polarization_i,
  input  wire logic [3*COMPONENT_WIDTH-1:0]           grad_row_x_i,
  input  wire logic [3*COMPONENT_WIDTH-1:0]           grad_row_y_i,
  input  wire logic [3*COMPONENT_WIDTH-1:0]           grad_row_z_i,
  input  wire logic [3*COMPONENT_WIDTH-1:0]           laplacian_vec_i,
  input  wire logic [3*COMPONENT_WIDTH-1:0]           dyad_lap_row_x_i,
  input  wire logic [3*COMPONENT_WIDTH-1:0]           dyad_lap_row_y_i,
  input  wire logic [3*COMPONENT_WIDTH-1:0]           dyad_lap_row_z_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic signed [pate_pkg::OUT_W-1:0]           stress_xx_o,
  output logic signed [pate_pkg::OUT_W-1:0]           stress_xy_o,
  output logic signed [pate_pkg::OUT_W-1:0]           stress_xz_o,
  output logic signed [pate_pkg::OUT_W-1:0]           stress_yx_o,
  output logic signed [pate_pkg::OUT_W-1:0]           stress_yy_o,
  output logic signed [pate_pkg::OUT_W-1:0]           stress_yz_o,
  output logic signed [pate_pkg::OUT_W-1:0]           stress_zx_o,
  output logic signed [pate_pkg::OUT_W-1:0]           stress_zy_o,
  output logic signed [pate_pkg::OUT_W-1:0]           stress_zz_o,
  input  wire logic                                   cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  wire logic [pate_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire logic [pate_pkg::CFG_W-1:0]             cfg_data_i
);

  localparam int NS = pate_pkg::STAGES;
  localparam int NF = pate_pkg::FRONT_STAGES;

  pate_pkg::cfg_t cfg_d, cfg_q;
  logic [NS:1]    vld_q;
  logic [NS:1]    en;

  logic signed [COMPONENT_WIDTH-1:0] p_w [3];
  pate_pkg::wide_t h_w [3];
  pate_pkg::mid_t  ppd_w [3][3];
  pate_pkg::acc_t  kgr_w [3][3];
  pate_pkg::out_t  stress_w [9];

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (pate_pkg::cfg_idx_e'(cfg_index_i))
        pate_pkg::CFG_COEF_A:      cfg_d.coef_a      = cfg_data_i;
        pate_pkg::CFG_COEF_B:      cfg_d.coef_b      = cfg_data_i;
        pate_pkg::CFG_ELASTIC_ONE: cfg_d.elastic_one = cfg_data_i;
        pate_pkg::CFG_ELASTIC_TWO: cfg_d.elastic_two = cfg_data_i;
        pate_pkg::CFG_ACTIVITY:    cfg_d.activity    = cfg_data_i;
        pate_pkg::CFG_FLOW_ALIGN:  cfg_d.flow_align  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_en
    assign en[k] = out_ready_i | ~(&vld_q[NS:k]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[1]) begin
        vld_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = en[1];
  assign out_valid_o = vld_q[NS];

  pate_front #(
    .COMPONENT_WIDTH (COMPONENT_WIDTH)
  ) u_front (
    .clk_i            (clk_i),
    .en_i             (en[NF:1]),
    .cfg_i            (cfg_q),
    .polarization_i   (polarization_i),
    .grad_row_x_i     (grad_row_x_i),
    .grad_row_y_i     (grad_row_y_i),
    .grad_row_z_i     (grad_row_z_i),
    .laplacian_vec_i  (laplacian_vec_i),
    .dyad_lap_row_x_i (dyad_lap_row_x_i),
    .dyad_lap_row_y_i (dyad_lap_row_y_i),
    .dyad_lap_row_z_i (dyad_lap_row_z_i),
    .p_o              (p_w),
    .h_o              (h_w),
    .ppd_o            (ppd_w),
    .kgr_o            (kgr_w)
  );

  pate_back #(
    .COMPONENT_WIDTH (COMPONENT_WIDTH)
  ) u_back (
    .clk_i    (clk_i),
    .en_i     (en[NS:NF+1]),
    .cfg_i    (cfg_q),
    .p_i      (p_w),
    .h_i      (h_w),
    .ppd_i    (ppd_w),
    .kgr_i    (kgr_w),
    .stress_o (stress_w)
  );

  assign stress_xx_o = stress_w[0];
  assign stress_xy_o = stress_w[1];
  assign stress_xz_o = stress_w[2];
  assign stress_yx_o = stress_w[3];
  assign stress_yy_o = stress_w[4];
  assign stress_yz_o = stress_w[5];
  assign stress_zx_o = stress_w[6];
  assign stress_zy_o = stress_w[7];
  assign stress_zz_o = stress_w[8];

endmodule
`default_nettype wire

/* hdl/pate_checker.sv */
`default_nettype none
`include "polar_active_stress_tensor_defines.svh"
module pate_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_ready_o,
  input wire logic                              out_valid_o,
  input wire logic                              out_ready_i,
  input wire logic signed [pate_pkg::OUT_W-1:0] stress_xx_o,
  input wire logic signed [pate_pkg::OUT_W-1:0] stress_xy_o,
  input wire logic signed [pate_pkg::OUT_W-1:0] stress_xz_o,
  input wire logic signed [pate_pkg::OUT_W-1:0] stress_yx_o,
  input wire logic signed [pate_pkg::OUT_W-1:0] stress_yy_o,
  input wire logic signed [pate_pkg::OUT_W-1:0] stress_yz_o,
  input wire logic signed [pate_pkg::OUT_W-1:0] stress_zx_o,
  input wire logic signed [pate_pkg::OUT_W-1:0] stress_zy_o,
  input wire logic signed [pate_pkg::OUT_W-1:0] stress_zz_o
);

  logic                              out_held;
  logic [9*pate_pkg::OUT_W-1:0]      out_word;

  assign out_held = out_valid_o & ~out_ready_i;
  assign out_word = {stress_xx_o, stress_xy_o, stress_xz_o, stress_yx_o, stress_yy_o,
                     stress_yz_o, stress_zx_o, stress_zy_o, stress_zz_o};

  `PATE_ASSERT(a_out_valid_holds, clk_i, rst_ni, out_held |=> out_valid_o)
  `PATE_ASSERT(a_out_word_holds, clk_i, rst_ni, out_held |=> $stable(out_word))
  `PATE_ASSERT(a_ready_when_free, clk_i, rst_ni, (!out_valid_o || out_ready_i) |-> in_ready_o)
  `PATE_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !out_valid_o && in_ready_o)

endmodule

bind polar_active_stress_tensor pate_checker u_pate_checker (.*);
`default_nettype wire

/* bench/testbench.sv */
`default_nettype none
module testbench;
  import pate_pkg::*;

  typedef logic [7:0][47:0] site_t;
  typedef logic [8:0][OUT_W-1:0] stress_t;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int DRAIN_CYCLES = 2 * STAGES;

  class stress_board;
    cfg_word_t regs[6];
    stress_t   expected_q[$];
    int        errors;

    function void clear_regs();
      for (int i = 0; i < 6; i++) regs[i] = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, cfg_word_t val);
      if (idx < 6) regs[idx] = val;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function longint part(logic [47:0] f, int k);
      logic signed [15:0] v;
      v = f[k*16 +: 16];
      return longint'(v);
    endfunction

    function longint rnd(longint x, int sh);
      return (x + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function longint clip(longint x, int bits);
      longint hi;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      if (x > hi) return hi;
      if (x < -hi - 1) return -hi - 1;
      return x;
    endfunction

    function longint third(longint x);
      if (x >= 0) return (x + 1) / 3;
      return -((-x + 1) / 3);
    endfunction

    function void note(site_t s);
      longint p[3], g[3][3], lp[3], dl[3][3], h[3];
      longint ca, cb, k1, k2, zeta, lam, p2, pdoth, u, sm, t;
      longint pab, pba, anti, sym, gg, pp, total;
      stress_t r;
      ca = regs[CFG_COEF_A];      cb = regs[CFG_COEF_B];
      k1 = regs[CFG_ELASTIC_ONE]; k2 = regs[CFG_ELASTIC_TWO];
      zeta = regs[CFG_ACTIVITY];  lam = regs[CFG_FLOW_ALIGN];
      for (int c = 0; c < 3; c++) begin
        p[c] = part(s[0], c);
        lp[c] = part(s[4], c);
        for (int a = 0; a < 3; a++) begin
          g[a][c] = part(s[1 + a], c);
          dl[a][c] = part(s[5 + a], c);
        end
      end
      p2 = clip(p[0] * p[0] + p[1] * p[1] + p[2] * p[2], WIDE_W);
      for (int a = 0; a < 3; a++) begin
        u = clip(rnd(p2 * p[a], FRAC), WIDE_W);
        sm = clip(p[0] * dl[0][a] + p[1] * dl[1][a] + p[2] * dl[2][a], WIDE_W);
        t = -ca * p[a] + k1 * lp[a] - rnd(cb * u, FRAC) + rnd(2 * k2 * sm, FRAC);
        h[a] = clip(t, WIDE_W);
      end
      pdoth = clip(rnd(p[0] * h[0] + p[1] * h[1] + p[2] * h[2], FRAC), WIDE_W);
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          pab = p[a] * h[b];
          pba = p[b] * h[a];
          anti = clip(rnd(pab - pba, FRAC + 1), WIDE_W);
          sym = clip(rnd(pab + pba, FRAC + 1), WIDE_W);
          gg = clip(g[a][0] * g[b][0] + g[a][1] * g[b][1] + g[a][2] * g[b][2], WIDE_W);
          pp = p[a] * p[b];
          if (a == b) begin
            sym -= third(pdoth);
            pp -= third(p2);
          end
          total = anti - rnd(lam * sym, FRAC) - rnd(k1 * gg, FRAC) - rnd(zeta * pp, FRAC);
          r[a * 3 + b] = OUT_W'(clip(-total, OUT_W));
        end
      end
      expected_q.push_back(r);
    endfunction

    task check(stress_t got);
      stress_t want;
      if (expected_q.size() == 0) begin
        report("stress word with nothing expected");
        return;
      end
      want = expected_q.pop_front();
      for (int i = 0; i < 9; i++)
        if (got[i] !== want[i])
          report($sformatf("stress component %0d%0d got %h want %h",
                           i / 3, i % 3, got[i], want[i]));
    endtask
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic cfg_valid_i, cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;
  site_t site_bus;
  stress_t got_bus;
  int send_idle, recv_idle;
  stress_board board;

  polar_active_stress_tensor uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .polarization_i(site_bus[0]), .grad_row_x_i(site_bus[1]),
    .grad_row_y_i(site_bus[2]), .grad_row_z_i(site_bus[3]),
    .laplacian_vec_i(site_bus[4]), .dyad_lap_row_x_i(site_bus[5]),
    .dyad_lap_row_y_i(site_bus[6]), .dyad_lap_row_z_i(site_bus[7]),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .stress_xx_o(got_bus[0]), .stress_xy_o(got_bus[1]), .stress_xz_o(got_bus[2]),
    .stress_yx_o(got_bus[3]), .stress_yy_o(got_bus[4]), .stress_yz_o(got_bus[5]),
    .stress_zx_o(got_bus[6]), .stress_zy_o(got_bus[7]), .stress_zz_o(got_bus[8]),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    clk_i = 1'b1; #6;
    clk_i = 1'b0; #6;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) board.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) board.note(site_bus);
      if (out_valid_o && out_ready_i) board.check(got_bus);
    end
  end

  always @(posedge clk_i)
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle);

  function automatic logic [15:0] pick_part();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3, 4, 5, 6, 7: return 16'($urandom_range(0, 16'h2000)) - 16'h1000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic site_t pick_site();
    site_t s;
    for (int f = 0; f < 8; f++) begin
      if ($urandom_range(0, 7) == 0) s[f] = {16'($urandom), $urandom};
      else s[f] = {pick_part(), pick_part(), pick_part()};
    end
    return s;
  endfunction

  task automatic send_site(site_t s);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    site_bus <= s;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_coefs(logic [CFG_W-1:0] a, logic [CFG_W-1:0] b, logic [CFG_W-1:0] k1,
                            logic [CFG_W-1:0] k2, logic [CFG_W-1:0] z, logic [CFG_W-1:0] l);
    write_reg(CFG_COEF_A, a);
    write_reg(CFG_COEF_B, b);
    write_reg(CFG_ELASTIC_ONE, k1);
    write_reg(CFG_ELASTIC_TWO, k2);
    write_reg(CFG_ACTIVITY, z);
    write_reg(CFG_FLOW_ALIGN, l);
    cfg_valid_i <= 1'b0;
  endtask

  // hold the sender until every stress word is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_same(logic [15:0] v);
    send_site({24{v}});
  endtask

  initial begin
    site_t s;
    logic [15:0] c;
    board = new();
    board.clear_regs();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    site_bus = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    send_idle = 0;
    recv_idle = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_same(16'h0000);
    send_same(16'h7FFF);
    send_same(16'h8000);
    drain();

    load_coefs(16'h1000, 16'h0800, 16'h0400, 16'h0200, 16'h0100, 16'h0C00);
    @(posedge clk_i);
    write_reg(CFG_SPARE_LO, 16'h7FFF);
    write_reg(CFG_SPARE_HI, 16'h8000);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    send_same(16'h0000);
    send_same(16'h1000);
    send_same(16'hF000);
    send_same(16'h7FFF);
    send_same(16'h8000);
    send_site({24{16'h5555}});
    send_site({24{16'hAAAA}});
    for (int k = 0; k < 3; k++) begin
      s = '0;
      s[0][k*16 +: 16] = 16'h1000;
      s[1 + k] = {3{16'h0800}};
      s[4][k*16 +: 16] = 16'hF800;
      s[5 + k] = {16'h0400, 16'h0C00, 16'hFC00};
      send_site(s);
    end
    for (int k = 0; k < 6; k++) send_site(pick_site());
    drain();

    load_coefs(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    for (int k = 0; k < 8; k++) send_site(pick_site());
    drain();
    load_coefs(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    for (int k = 0; k < 8; k++) send_site(pick_site());
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph / 3)
        0: begin send_idle = 36; recv_idle = 72; end
        1: begin send_idle = 72; recv_idle = 36; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      if (ph % 3 == 2) begin
        load_coefs(16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        c = 16'($urandom_range(0, 16'h1000)) - 16'h0800;
        load_coefs(c, 16'($urandom_range(0, 16'h0800)), 16'($urandom_range(0, 16'h1000)) - 16'h0800,
                   16'($urandom_range(0, 16'h0800)) - 16'h0400, 16'($urandom_range(0, 16'h1000)) - 16'h0800,
                   16'($urandom_range(0, 16'h2000)) - 16'h1000);
      end
      for (int k = 0; k < 85; k++) send_site(pick_site());
      drain();
    end

    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(12 * 1000000);
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
